[rtl/ffba_pkg.sv]
// Package for the first-fit block allocator.
// Holds transaction types, status codes, sequencer states and default sizes.
// No dependencies.
package ffba_pkg;

  localparam int HeapBlocksDef      = 4096;
  localparam int MaxFreeSegmentsDef = 64;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_NOFIT = 3'd1,
    ST_RANGE = 3'd2,
    ST_BAD   = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e        command;
    logic [12:0] size_blocks;
    logic [12:0] block_addr;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [11:0] result_addr;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_F_LK,
    S_F_RD,
    S_F_CHK,
    S_F_DEC,
    S_SH_RD,
    S_SH_WR,
    S_FIN
  } state_e;

endpackage

[rtl/ffba_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/first_fit_block_allocator_unit.sv]
// First-fit block allocator with a coalescing, address-ordered free table.
// Early errors answer from idle. Allocate splits the first fitting entry or removes an
// exact fit by shifting entries down. Free rejects unrecorded blocks, merges with one or
// both neighbours (both shifts down), inserts by shifting up, or reports a full table.
// Throughput: one transaction at a time, next accepted in the done_o cycle; no stall.
// Reset: the size store is cleared with busy high.
module first_fit_block_allocator_unit #(
  parameter int HEAP_BLOCKS       = ffba_pkg::HeapBlocksDef,
  parameter int MAX_FREE_SEGMENTS = ffba_pkg::MaxFreeSegmentsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ffba_pkg::req_t req_i,
  output logic          done_o,
  output ffba_pkg::rsp_t rsp_o
);

  localparam int AW = $clog2(HEAP_BLOCKS);
  localparam int LW = $clog2(HEAP_BLOCKS + 1);
  localparam int IW = $clog2(MAX_FREE_SEGMENTS);
  localparam int CW = $clog2(MAX_FREE_SEGMENTS + 1);
  localparam int EW = AW + LW;

  ffba_pkg::state_e state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d, idx_q, idx_d, k_q, k_d;
  logic             init_q, init_d, up_q, up_d, rd_zero_q, rd_zero_d;
  logic [AW-1:0]    clr_q, clr_d, addr_q, addr_d;
  logic [LW-1:0]    size_q, size_d, sz_q, sz_d;
  ffba_pkg::cmd_e   cmd_q, cmd_d;
  logic [EW-1:0]    prev_q, prev_d, nxt_q, nxt_d;
  logic             done_q, done_d;
  ffba_pkg::rsp_t   rsp_q, rsp_d;

  logic          tb_we;
  logic [IW-1:0] tb_waddr, tb_raddr;
  logic [EW-1:0] tb_wdata, tb_ram, tb_rd;
  logic          as_we;
  logic [AW-1:0] as_waddr, as_raddr;
  logic [LW-1:0] as_wdata, as_rd;

  logic [AW-1:0] rd_start, p_start, n_start;
  logic [LW-1:0] rd_len, p_len, n_len;
  logic          req_go, too_big, out_rng, fit, exact, more, kmore, kup, lt, hp, hn, full;
  logic          clr_last;
  logic [CW-1:0] idx_p1, idx_m1, k_p1, k_m1;

  ffba_ram #(.WIDTH(EW), .DEPTH(MAX_FREE_SEGMENTS)) u_table (
    .clk_i  (clk_i),
    .we_i   (tb_we),
    .waddr_i(tb_waddr),
    .wdata_i(tb_wdata),
    .raddr_i(tb_raddr),
    .rdata_o(tb_ram)
  );

  ffba_ram #(.WIDTH(LW), .DEPTH(HEAP_BLOCKS)) u_sizes (
    .clk_i  (clk_i),
    .we_i   (as_we),
    .waddr_i(as_waddr),
    .wdata_i(as_wdata),
    .raddr_i(as_raddr),
    .rdata_o(as_rd)
  );

  // Entry zero reads as the whole heap until first written
  assign tb_rd    = rd_zero_q ? {AW'(0), LW'(HEAP_BLOCKS)} : tb_ram;
  assign rd_start = tb_rd[EW-1:LW];
  assign rd_len   = tb_rd[LW-1:0];
  assign p_start  = prev_q[EW-1:LW];
  assign p_len    = prev_q[LW-1:0];
  assign n_start  = nxt_q[EW-1:LW];
  assign n_len    = nxt_q[LW-1:0];

  assign idx_p1 = idx_q + 1'b1;
  assign idx_m1 = idx_q - 1'b1;
  assign k_p1   = k_q + 1'b1;
  assign k_m1   = k_q - 1'b1;

  // Shared decisions
  assign busy     = (state_q != ffba_pkg::S_IDLE);
  assign req_go   = start && !busy;
  assign too_big  = 32'(req_i.size_blocks) > 32'(HEAP_BLOCKS);
  assign out_rng  = 32'(req_i.block_addr) >= 32'(HEAP_BLOCKS);
  assign fit      = rd_len >= size_q;
  assign exact    = rd_len == size_q;
  assign more     = (CW + 1)'(idx_q) + 1'b1 < (CW + 1)'(cnt_q);
  assign kmore    = (CW + 1)'(k_q) + 1'b1 < (CW + 1)'(cnt_q);
  assign kup      = k_q > idx_q;
  assign lt       = rd_start < addr_q;
  assign hp       = (idx_q != '0) &&
                    ((LW + 1)'(p_start) + (LW + 1)'(p_len) == (LW + 1)'(addr_q));
  assign hn       = (idx_q < cnt_q) &&
                    ((LW + 1)'(addr_q) + (LW + 1)'(sz_q) == (LW + 1)'(n_start));
  assign full     = 32'(cnt_q) >= 32'(MAX_FREE_SEGMENTS);
  assign clr_last = clr_q == AW'(HEAP_BLOCKS - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffba_pkg::S_CLEAR: if (clr_last) state_d = ffba_pkg::S_IDLE;
      ffba_pkg::S_IDLE: begin
        if (req_go) begin
          if (req_i.command == ffba_pkg::CMD_ALLOC) begin
            if (req_i.size_blocks != '0 && !too_big && cnt_q != '0) begin
              state_d = ffba_pkg::S_A_RD;
            end
          end else if (!out_rng) begin
            state_d = ffba_pkg::S_F_LK;
          end
        end
      end
      ffba_pkg::S_A_RD: state_d = ffba_pkg::S_A_CHK;
      ffba_pkg::S_A_CHK: begin
        if (fit) state_d = exact ? ffba_pkg::S_SH_RD : ffba_pkg::S_FIN;
        else     state_d = more ? ffba_pkg::S_A_RD : ffba_pkg::S_IDLE;
      end
      ffba_pkg::S_F_LK: begin
        if (as_rd == '0)      state_d = ffba_pkg::S_IDLE;
        else if (cnt_q == '0) state_d = ffba_pkg::S_F_DEC;
        else                  state_d = ffba_pkg::S_F_RD;
      end
      ffba_pkg::S_F_RD: state_d = ffba_pkg::S_F_CHK;
      ffba_pkg::S_F_CHK: state_d = (lt && more) ? ffba_pkg::S_F_RD : ffba_pkg::S_F_DEC;
      ffba_pkg::S_F_DEC: begin
        if (hp && hn)      state_d = ffba_pkg::S_SH_RD;
        else if (hp || hn) state_d = ffba_pkg::S_FIN;
        else if (full)     state_d = ffba_pkg::S_IDLE;
        else               state_d = ffba_pkg::S_SH_RD;
      end
      ffba_pkg::S_SH_RD: begin
        if (up_q) state_d = kup ? ffba_pkg::S_SH_WR : ffba_pkg::S_FIN;
        else      state_d = kmore ? ffba_pkg::S_SH_WR : ffba_pkg::S_FIN;
      end
      ffba_pkg::S_SH_WR: state_d = ffba_pkg::S_SH_RD;
      ffba_pkg::S_FIN:   state_d = ffba_pkg::S_IDLE;
      default:           state_d = ffba_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory controls and results
  always_comb begin
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    k_d      = k_q;
    up_d     = up_q;
    clr_d    = clr_q;
    addr_d   = addr_q;
    size_d   = size_q;
    sz_d     = sz_q;
    cmd_d    = cmd_q;
    prev_d   = prev_q;
    nxt_d    = nxt_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    tb_we    = 1'b0;
    tb_waddr = k_q[IW-1:0];
    tb_wdata = tb_rd;
    tb_raddr = idx_q[IW-1:0];
    as_we    = 1'b0;
    as_waddr = addr_q;
    as_wdata = '0;
    as_raddr = AW'(req_i.block_addr);

    unique case (state_q)
      ffba_pkg::S_CLEAR: begin
        as_we    = 1'b1;
        as_waddr = clr_q;
        clr_d    = clr_q + 1'b1;
      end
      ffba_pkg::S_IDLE: begin
        if (req_go) begin
          cmd_d  = req_i.command;
          size_d = LW'(req_i.size_blocks);
          addr_d = AW'(req_i.block_addr);
          idx_d  = '0;
          rsp_d.result_addr = '0;
          if (req_i.command == ffba_pkg::CMD_ALLOC) begin
            if (req_i.size_blocks == '0) begin
              done_d = 1'b1;
              rsp_d.status = ffba_pkg::ST_BAD;
            end else if (too_big || cnt_q == '0) begin
              done_d = 1'b1;
              rsp_d.status = ffba_pkg::ST_NOFIT;
            end
          end else if (out_rng) begin
            done_d = 1'b1;
            rsp_d.status = ffba_pkg::ST_RANGE;
          end
        end
      end
      ffba_pkg::S_A_RD: tb_raddr = idx_q[IW-1:0];
      ffba_pkg::S_A_CHK: begin
        if (fit) begin
          addr_d = rd_start;
          if (exact) begin
            k_d  = idx_q;
            up_d = 1'b0;
          end else begin
            tb_we    = 1'b1;
            tb_waddr = idx_q[IW-1:0];
            tb_wdata = {AW'(LW'(rd_start) + size_q), rd_len - size_q};
          end
        end else if (more) begin
          idx_d = idx_p1;
        end else begin
          done_d = 1'b1;
          rsp_d.status = ffba_pkg::ST_NOFIT;
          rsp_d.result_addr = '0;
        end
      end
      ffba_pkg::S_F_LK: begin
        sz_d = as_rd;
        if (as_rd == '0) begin
          done_d = 1'b1;
          rsp_d.status = ffba_pkg::ST_BAD;
        end
      end
      ffba_pkg::S_F_RD: tb_raddr = idx_q[IW-1:0];
      ffba_pkg::S_F_CHK: begin
        if (lt) begin
          prev_d = tb_rd;
          idx_d  = idx_p1;
        end else begin
          nxt_d = tb_rd;
        end
      end
      ffba_pkg::S_F_DEC: begin
        if (hp) begin
          tb_we    = 1'b1;
          tb_waddr = idx_m1[IW-1:0];
          tb_wdata = hn ? {p_start, p_len + sz_q + n_len} : {p_start, p_len + sz_q};
          k_d      = idx_q;
          up_d     = 1'b0;
        end else if (hn) begin
          tb_we    = 1'b1;
          tb_waddr = idx_q[IW-1:0];
          tb_wdata = {addr_q, n_len + sz_q};
        end else if (full) begin
          done_d = 1'b1;
          rsp_d.status = ffba_pkg::ST_FULL;
        end else begin
          k_d  = cnt_q;
          up_d = 1'b1;
        end
      end
      ffba_pkg::S_SH_RD: begin
        if (up_q) begin
          tb_raddr = k_m1[IW-1:0];
          if (!kup) begin
            tb_we    = 1'b1;
            tb_waddr = idx_q[IW-1:0];
            tb_wdata = {addr_q, sz_q};
            cnt_d    = cnt_q + 1'b1;
          end
        end else begin
          tb_raddr = k_p1[IW-1:0];
          if (!kmore) cnt_d = cnt_q - 1'b1;
        end
      end
      ffba_pkg::S_SH_WR: begin
        tb_we    = 1'b1;
        tb_waddr = k_q[IW-1:0];
        tb_wdata = tb_rd;
        k_d      = up_q ? k_m1 : k_p1;
      end
      ffba_pkg::S_FIN: begin
        as_we    = 1'b1;
        as_waddr = addr_q;
        as_wdata = (cmd_q == ffba_pkg::CMD_ALLOC) ? size_q : '0;
        done_d   = 1'b1;
        rsp_d.status = ffba_pkg::ST_OK;
        rsp_d.result_addr = (cmd_q == ffba_pkg::CMD_ALLOC) ? 12'(addr_q) : 12'd0;
      end
      default: ;
    endcase
  end

  // Track entry zero until first written, and tag reads of it
  assign init_d    = init_q && !(tb_we && tb_waddr == '0);
  assign rd_zero_d = init_q && (tb_raddr == '0);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ffba_pkg::S_CLEAR;
      cnt_q     <= CW'(1);
      init_q    <= 1'b1;
      clr_q     <= '0;
      done_q    <= 1'b0;
      up_q      <= 1'b0;
      rd_zero_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      init_q    <= init_d;
      clr_q     <= clr_d;
      done_q    <= done_d;
      up_q      <= up_d;
      rd_zero_q <= rd_zero_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    k_q    <= k_d;
    addr_q <= addr_d;
    size_q <= size_d;
    sz_q   <= sz_d;
    cmd_q  <= cmd_d;
    prev_q <= prev_d;
    nxt_q  <= nxt_d;
    rsp_q  <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

[rtl/ffba_chk.sv]
// Port-level checker for the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator_unit.
module ffba_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input ffba_pkg::rsp_t rsp_o
);

  // Results arrive only when the unit is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

  // Failed transactions return address zero
  a_err_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ffba_pkg::ST_OK |-> rsp_o.result_addr == 12'd0)
    else $error("nonzero address on error");

  // Every result follows an accepted transaction or ongoing work
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) || $past(start)) else $error("spurious result");

  // Status codes stay in the defined set
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.status <= ffba_pkg::ST_FULL) else $error("bad status");

endmodule

bind first_fit_block_allocator_unit ffba_chk u_ffba_chk (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);
